// ===== rtl/tcse_pkg.sv =====
// Shared constants for the text console scroll engine.
`default_nettype none

package tcse_pkg;

  // default geometry
  localparam int unsigned COLUMNS_DEF      = 80;
  localparam int unsigned ROWS_DEF         = 25;
  localparam int unsigned HISTORY_ROWS_DEF = 64;

  // cell word: colour in the high byte, character in the low byte
  localparam int unsigned CELL_W = 16;

  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  // operation codes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // configuration register indexes
  localparam logic CFG_DEFAULT_COLOR = 1'b0;
  localparam logic CFG_BLANK_ROWS    = 1'b1;

  localparam logic [7:0] DEFAULT_COLOR_RST = 8'h07;
  localparam logic [4:0] BLANK_ROWS_RST    = 5'd2;

  localparam int unsigned BLANK_W  = 5;
  localparam int unsigned CURSOR_W = 11;
  localparam int unsigned WINDOW_W = 6;

endpackage

`default_nettype wire

// ===== rtl/tcse_cell_ram.sv =====
// Single-port cell store with registered read data.
`default_nettype none

module tcse_cell_ram
  import tcse_pkg::*;
#(
  parameter int unsigned DEPTH = COLUMNS_DEF * HISTORY_ROWS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     addr_i,
  input  wire logic [CELL_W-1:0] wdata_i,
  output logic      [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/tcse_view.sv =====
// Window top and flat cursor from the write row, keeping blank rows free below.
`default_nettype none

module tcse_view
  import tcse_pkg::*;
#(
  parameter int unsigned COLUMNS      = COLUMNS_DEF,
  parameter int unsigned ROWS         = ROWS_DEF,
  parameter int unsigned HISTORY_ROWS = HISTORY_ROWS_DEF
) (
  input  wire logic [$clog2(HISTORY_ROWS)-1:0] row_i,
  input  wire logic [BLANK_W-1:0]              blank_rows_i,
  output logic      [$clog2(HISTORY_ROWS)-1:0] window_o,
  output logic      [CURSOR_W-1:0]             cursor_o
);

  localparam int unsigned RW = $clog2(HISTORY_ROWS);
  localparam int unsigned VW = (RW > 6 ? RW : 6) + 1;
  localparam int unsigned PW = VW + 9;

  logic [VW-1:0] blanks;
  logic [VW-1:0] writable;
  logic [VW-1:0] row_x;
  logic [VW-1:0] line;
  logic [VW-1:0] win_x;
  logic [PW-1:0] prod;

  always_comb begin
    // a blank count of ROWS or more leaves one writable row
    blanks   = (VW'(blank_rows_i) >= VW'(ROWS)) ? VW'(ROWS - 1) : VW'(blank_rows_i);
    writable = VW'(ROWS) - blanks;
    row_x    = VW'(row_i);
    if (row_x >= writable) begin
      win_x = row_x - writable + VW'(1);
      line  = writable - VW'(1);
    end else begin
      win_x = '0;
      line  = row_x;
    end
    window_o = win_x[RW-1:0];
    prod     = PW'(line) * PW'(COLUMNS);
    cursor_o = prod[CURSOR_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/text_console_scroll_engine.sv =====
// Top level: command sequencer around the cell store.
//
// Usage: raise start with func, char_code, char_color, read_row and read_col;
// the word is taken at a clock edge where start is high and busy is low. Each
// word gives exactly one result, shown for one cycle with done_o high; the
// receiver cannot stall, so it must take the result in that cycle.
// cursor_index_o and window_top_o hold the latched view at all times.
// Steps per word, from the accept edge to done_o:
//   put of a plain character       store write
//   put that wraps to the next row advance, scroll when the store scrolls, write
//   newline                        advance, scroll when the store scrolls, latch view
//   clear                          every cell to spaces (one cell a cycle), latch view
//   read                           address, store read, data register;
//                                  a range check alone when outside the screen or below the store
//   unused func code               answered from idle
// The single store port, one cell per cycle, sets the scroll and clear length.
// Reset: the store is swept to spaces in colour 7, one cell a cycle, with busy
// high throughout. Config writes must be made only while the block is idle
// for them to apply as intended; the block itself does not enforce this.
`default_nettype none

module text_console_scroll_engine
  import tcse_pkg::*;
#(
  parameter int unsigned COLUMNS      = COLUMNS_DEF,
  parameter int unsigned ROWS         = ROWS_DEF,
  parameter int unsigned HISTORY_ROWS = HISTORY_ROWS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          func_i,
  input  wire logic [7:0]          char_code_i,
  input  wire logic [7:0]          char_color_i,
  input  wire logic [4:0]          read_row_i,
  input  wire logic [6:0]          read_col_i,
  output logic                     done_o,
  output logic [CURSOR_W-1:0]      cursor_index_o,
  output logic [WINDOW_W-1:0]      window_top_o,
  output logic                     cursor_changed_o,
  output logic [7:0]               cell_char_o,
  output logic [7:0]               cell_color_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [7:0]          cfg_wdata_i
);

  localparam int unsigned CELLS = COLUMNS * HISTORY_ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(HISTORY_ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned VW    = (RW > 6 ? RW : 6) + 1;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ADV    = 4'd2;
  localparam logic [3:0] S_SCROLL = 4'd3;
  localparam logic [3:0] S_WRITE  = 4'd4;
  localparam logic [3:0] S_CLEAR  = 4'd5;
  localparam logic [3:0] S_LATCH  = 4'd6;
  localparam logic [3:0] S_RD0    = 4'd7;
  localparam logic [3:0] S_RD1    = 4'd8;
  localparam logic [3:0] S_RD2    = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic [RW-1:0]       row_q, row_d;
  logic [CW-1:0]       col_q, col_d;
  logic [AW-1:0]       wbase_q, wbase_d;
  logic [AW-1:0]       tbase_q, tbase_d;
  logic [RW-1:0]       top_q, top_d;
  logic [CURSOR_W-1:0] lcur_q, lcur_d;
  logic [RW-1:0]       lwin_q, lwin_d;
  logic [7:0]          dcolor_q, dcolor_d;
  logic [BLANK_W-1:0]  blank_q, blank_d;
  logic                done_q, done_d;
  logic                chg_q, chg_d;
  logic [7:0]          cchar_q, cchar_d;
  logic [7:0]          ccolor_q, ccolor_d;

  // captured word, no reset
  logic [7:0]          code_q, code_d;
  logic [7:0]          color_q, color_d;
  logic [4:0]          rrow_q, rrow_d;
  logic [6:0]          rcol_q, rcol_d;
  logic [RW-1:0]       phys_q, phys_d;

  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [CELL_W-1:0]   mem_wdata;
  logic [CELL_W-1:0]   mem_rdata;

  logic [RW-1:0]       view_win;
  logic [CURSOR_W-1:0] view_cur;

  logic [AW:0]         wbase_sum, tbase_sum;
  logic [AW-1:0]       wbase_inc, tbase_inc;
  logic [RW-1:0]       top_inc;
  logic                is_nl;
  logic [RW:0]         logical;
  logic [RW+1:0]       phys_sum;
  logic [AW-1:0]       rd_addr;

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign cursor_index_o   = lcur_q;
  assign window_top_o     = WINDOW_W'(lwin_q);
  assign cursor_changed_o = chg_q;
  assign cell_char_o      = cchar_q;
  assign cell_color_o     = ccolor_q;

  tcse_view #(
    .COLUMNS      (COLUMNS),
    .ROWS         (ROWS),
    .HISTORY_ROWS (HISTORY_ROWS)
  ) u_view (
    .row_i        (row_q),
    .blank_rows_i (blank_q),
    .window_o     (view_win),
    .cursor_o     (view_cur)
  );

  tcse_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    // row bases step by one row and wrap at the end of the store
    wbase_sum = {1'b0, wbase_q} + (AW+1)'(COLUMNS);
    wbase_inc = (wbase_sum >= (AW+1)'(CELLS)) ? '0 : wbase_sum[AW-1:0];
    tbase_sum = {1'b0, tbase_q} + (AW+1)'(COLUMNS);
    tbase_inc = (tbase_sum >= (AW+1)'(CELLS)) ? '0 : tbase_sum[AW-1:0];
    top_inc   = (top_q == RW'(HISTORY_ROWS - 1)) ? '0 : top_q + RW'(1);
    is_nl     = (code_q == NEWLINE_CODE);
    logical   = (RW+1)'(lwin_q) + (RW+1)'(rrow_q);
    phys_sum  = (RW+2)'(top_q) + (RW+2)'(logical);
    if (phys_sum >= (RW+2)'(HISTORY_ROWS)) begin
      phys_sum = phys_sum - (RW+2)'(HISTORY_ROWS);
    end
    rd_addr   = AW'(phys_q) * AW'(COLUMNS) + AW'(rcol_q);
  end

  // store port
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = wbase_q + AW'(col_q);
    mem_wdata = {color_q, code_q};
    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_addr  = cnt_q;
        mem_wdata = {DEFAULT_COLOR_RST, SPACE_CODE};
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = cnt_q;
        mem_wdata = {color_q, SPACE_CODE};
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_addr  = tbase_q + cnt_q;
        mem_wdata = {dcolor_q, SPACE_CODE};
      end
      S_WRITE: begin
        mem_we = 1'b1;
      end
      S_RD1: begin
        mem_addr = rd_addr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    row_d    = row_q;
    col_d    = col_q;
    wbase_d  = wbase_q;
    tbase_d  = tbase_q;
    top_d    = top_q;
    lcur_d   = lcur_q;
    lwin_d   = lwin_q;
    dcolor_d = dcolor_q;
    blank_d  = blank_q;
    code_d   = code_q;
    color_d  = color_q;
    rrow_d   = rrow_q;
    rcol_d   = rcol_q;
    phys_d   = phys_q;
    done_d   = 1'b0;
    chg_d    = 1'b0;
    cchar_d  = '0;
    ccolor_d = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEFAULT_COLOR: dcolor_d = cfg_wdata_i;
        CFG_BLANK_ROWS:    blank_d  = cfg_wdata_i[BLANK_W-1:0];
        default:           dcolor_d = dcolor_q;
      endcase
    end

    case (state_q)
      S_INIT: begin
        if (cnt_q == AW'(CELLS - 1)) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          code_d  = char_code_i;
          color_d = char_color_i;
          rrow_d  = read_row_i;
          rcol_d  = read_col_i;
          cnt_d   = '0;
          case (func_i)
            FUNC_PUT: begin
              if (char_code_i == NEWLINE_CODE || col_q == CW'(COLUMNS)) begin
                state_d = S_ADV;
              end else begin
                state_d = S_WRITE;
              end
            end
            FUNC_CLEAR: state_d = S_CLEAR;
            FUNC_READ:  state_d = S_RD0;
            default:    done_d  = 1'b1;
          endcase
        end
      end
      S_ADV: begin
        col_d = '0;
        if (row_q == RW'(HISTORY_ROWS - 1)) begin
          state_d = S_SCROLL;
        end else begin
          row_d   = row_q + RW'(1);
          wbase_d = wbase_inc;
          state_d = is_nl ? S_LATCH : S_WRITE;
        end
      end
      S_SCROLL: begin
        // blank the dropped top row; it becomes the new bottom row
        if (cnt_q == AW'(COLUMNS - 1)) begin
          tbase_d = tbase_inc;
          top_d   = top_inc;
          wbase_d = wbase_inc;
          state_d = is_nl ? S_LATCH : S_WRITE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_WRITE: begin
        col_d   = col_q + CW'(1);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_CLEAR: begin
        if (cnt_q == AW'(CELLS - 1)) begin
          row_d   = '0;
          col_d   = '0;
          top_d   = '0;
          tbase_d = '0;
          wbase_d = '0;
          state_d = S_LATCH;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      S_LATCH: begin
        lwin_d  = view_win;
        lcur_d  = view_cur;
        chg_d   = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_RD0: begin
        if (VW'(rrow_q) >= VW'(ROWS) || 9'(rcol_q) >= 9'(COLUMNS)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (logical >= (RW+1)'(HISTORY_ROWS)) begin
          // below the last store row: blank cell
          cchar_d  = SPACE_CODE;
          ccolor_d = dcolor_q;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          phys_d  = phys_sum[RW-1:0];
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        state_d = S_RD2;
      end
      S_RD2: begin
        cchar_d  = mem_rdata[7:0];
        ccolor_d = mem_rdata[15:8];
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      cnt_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
      wbase_q  <= '0;
      tbase_q  <= '0;
      top_q    <= '0;
      lcur_q   <= '0;
      lwin_q   <= '0;
      dcolor_q <= DEFAULT_COLOR_RST;
      blank_q  <= BLANK_ROWS_RST;
      done_q   <= 1'b0;
      chg_q    <= 1'b0;
      cchar_q  <= '0;
      ccolor_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      row_q    <= row_d;
      col_q    <= col_d;
      wbase_q  <= wbase_d;
      tbase_q  <= tbase_d;
      top_q    <= top_d;
      lcur_q   <= lcur_d;
      lwin_q   <= lwin_d;
      dcolor_q <= dcolor_d;
      blank_q  <= blank_d;
      done_q   <= done_d;
      chg_q    <= chg_d;
      cchar_q  <= cchar_d;
      ccolor_q <= ccolor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    color_q <= color_d;
    rrow_q  <= rrow_d;
    rcol_q  <= rcol_d;
    phys_q  <= phys_d;
  end

  // an accepted word either keeps the block busy or answers right away
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted word neither started nor answered");

  a_changed_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_changed_o |-> done_o)
    else $error("cursor_changed outside a result");

  a_store_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, mem_addr} < (AW+1)'(CELLS)))
    else $error("store write beyond last cell");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= CW'(COLUMNS))
    else $error("write column past screen width");

  a_write_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE |-> col_q < CW'(COLUMNS))
    else $error("cell write with column at screen width");

endmodule

`default_nettype wire
